// File: rtl/stereo_biquad_filter_macros.svh
// ----------------------------------------------------------------------------
// Stereo biquad filter assertion macros
// Concurrent assertion helpers used by the filter controller.
// ----------------------------------------------------------------------------
`ifndef STEREO_BIQUAD_FILTER_MACROS_SVH
`define STEREO_BIQUAD_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
`define SBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbq assertion failed");
`define SBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbq assertion failed");
`else
`define SBQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SBQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// Stereo biquad filter package
// Types, register indexes and constants shared by the filter modules.
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_COEF   = 6;
  localparam int TAP_W      = 4;
  localparam int ACC_W      = 32;
  localparam int SAT_W      = 28;

  localparam logic [TAP_W-1:0] LAST_TAP  = 4'd11;
  localparam logic [TAP_W-1:0] TAPS_PER_CH = 4'd6;
  localparam logic [3:0]       BASE_SHIFT = 4'd13;

  localparam logic signed [ACC_W-1:0] SAT_HIGH = 32'sh07FF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LOW  = -32'sh0800_0000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_B_OLDEST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B_MIDDLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_NEWEST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A_OLDEST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A_MIDDLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A_STALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd7;

  // filter modes
  localparam logic [1:0] MODE_PLAIN      = 2'd0;
  localparam logic [1:0] MODE_BANDPASS   = 2'd1;
  localparam logic [1:0] MODE_BANDREJECT = 2'd2;

  // history slots relative to the current one
  localparam logic [1:0] SLOT_OLD = 2'd0;
  localparam logic [1:0] SLOT_MID = 2'd1;
  localparam logic [1:0] SLOT_CUR = 2'd2;

  localparam logic [1:0] HIST_IDX_RESET = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] coef_t;

  localparam coef_t COEF_RESET [NUM_COEF] = '{
    -16'sd9830, -16'sd19660, 16'sd19660, 16'sd9830, 16'sd19660, 16'sd0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SAT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic [TAP_W-1:0] tap;
    logic             sat;
    logic             out_load;
  } cmd_t;

endpackage

// File: rtl/sbq_in_if.sv
// ----------------------------------------------------------------------------
// Stereo biquad input stream interface
// Valid/ready channel carrying one stereo sample word.
// ----------------------------------------------------------------------------
interface sbq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sbq_pkg::SAMPLE_W-1:0]    left_in;
  logic signed [sbq_pkg::SAMPLE_W-1:0]    right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

// File: rtl/sbq_out_if.sv
// ----------------------------------------------------------------------------
// Stereo biquad output stream interface
// Valid/ready channel carrying one filtered stereo sample word.
// ----------------------------------------------------------------------------
interface sbq_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sbq_pkg::SAMPLE_W-1:0]    left_out;
  logic signed [sbq_pkg::SAMPLE_W-1:0]    right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// File: rtl/sbq_ctrl.sv
// ----------------------------------------------------------------------------
// Stereo biquad controller
// Sequences load, twelve shared multiply-accumulates, saturation and output.
// ----------------------------------------------------------------------------
`include "stereo_biquad_filter_macros.svh"

module sbq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sbq_pkg::cmd_t cmd
);

  sbq_pkg::state_t                 state_r, state_nxt;
  logic [sbq_pkg::TAP_W-1:0]       tap_r, tap_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbq_pkg::ST_IDLE;
      tap_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      sbq_pkg::ST_IDLE: begin
        tap_nxt = '0;
        if (in_valid) state_nxt = sbq_pkg::ST_MAC;
      end
      sbq_pkg::ST_MAC: begin
        tap_nxt = tap_r + 1'b1;
        if (tap_r == sbq_pkg::LAST_TAP) state_nxt = sbq_pkg::ST_DRAIN;
      end
      sbq_pkg::ST_DRAIN: state_nxt = sbq_pkg::ST_SAT;
      sbq_pkg::ST_SAT:   state_nxt = sbq_pkg::ST_OUT;
      sbq_pkg::ST_OUT: begin
        if (out_free) state_nxt = sbq_pkg::ST_IDLE;
      end
      default: state_nxt = sbq_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.tap      = tap_r;
    unique case (state_r)
      sbq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sbq_pkg::ST_MAC:   cmd.mul = 1'b1;
      sbq_pkg::ST_DRAIN: cmd.mul = 1'b0;
      sbq_pkg::ST_SAT:   cmd.sat = 1'b1;
      sbq_pkg::ST_OUT:   cmd.out_load = out_free;
      default:           cmd = '0;
    endcase
  end

  // hold the result until taken, reload when a new one is ready
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  `SBQ_ASSERT_IMP(a_load_into_free, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `SBQ_ASSERT_IMP(a_tap_in_range, clk, rst_n, state_r == sbq_pkg::ST_MAC, tap_r <= sbq_pkg::LAST_TAP)
  `SBQ_ASSERT_NXT(a_accept_starts_mac, clk, rst_n, in_valid && in_ready, state_r == sbq_pkg::ST_MAC && tap_r == '0)
  `SBQ_ASSERT_NXT(a_load_shows_word, clk, rst_n, cmd.out_load, out_valid_r && state_r == sbq_pkg::ST_IDLE)

endmodule

// File: rtl/sbq_dp.sv
// ----------------------------------------------------------------------------
// Stereo biquad datapath
// Coefficient registers, sample histories, shared multiplier and accumulators.
// ----------------------------------------------------------------------------
module sbq_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [sbq_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sbq_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  sbq_pkg::cmd_t                          cmd,
  input  logic signed [sbq_pkg::SAMPLE_W-1:0]    left_in,
  input  logic signed [sbq_pkg::SAMPLE_W-1:0]    right_in,
  output logic signed [sbq_pkg::SAMPLE_W-1:0]    left_out,
  output logic signed [sbq_pkg::SAMPLE_W-1:0]    right_out
);

  sbq_pkg::coef_t                        coef_r [sbq_pkg::NUM_COEF];
  logic [3:0]                            gain_r;
  logic [1:0]                            mode_r;

  logic [1:0]                            hist_idx_r;
  logic signed [sbq_pkg::SAMPLE_W-1:0]   in_hist_r  [6];
  logic signed [sbq_pkg::SAMPLE_W-1:0]   out_hist_r [6];

  logic signed [sbq_pkg::ACC_W-1:0]      prod_r;
  logic                                  prod_vld_r;
  logic                                  prod_sub_r;
  logic                                  prod_ch_r;
  logic signed [sbq_pkg::ACC_W-1:0]      acc_r [2];

  logic signed [sbq_pkg::SAMPLE_W-1:0]   out_left_r, out_right_r;

  logic [1:0]                            cur_slot, old_slot, mid_slot, next_slot, sel_slot;
  logic                                  tap_ch;
  logic [2:0]                            tap_loc;
  logic [2:0]                            coef_sel;
  logic signed [sbq_pkg::SAMPLE_W-1:0]   operand;
  logic [3:0]                            gain_eff;
  logic [3:0]                            shamt;
  logic signed [sbq_pkg::SAT_W-1:0]      sat_v   [2];
  logic signed [sbq_pkg::SAT_W-1:0]      shift_v [2];
  logic signed [sbq_pkg::SAMPLE_W-1:0]   res_v   [2];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sbq_pkg::NUM_COEF; i++) coef_r[i] <= sbq_pkg::COEF_RESET[i];
      gain_r <= '0;
      mode_r <= sbq_pkg::MODE_PLAIN;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sbq_pkg::REG_B_OLDEST: coef_r[0] <= cfg_wdata;
        sbq_pkg::REG_B_MIDDLE: coef_r[1] <= cfg_wdata;
        sbq_pkg::REG_B_NEWEST: coef_r[2] <= cfg_wdata;
        sbq_pkg::REG_A_OLDEST: coef_r[3] <= cfg_wdata;
        sbq_pkg::REG_A_MIDDLE: coef_r[4] <= cfg_wdata;
        sbq_pkg::REG_A_STALE:  coef_r[5] <= cfg_wdata;
        sbq_pkg::REG_GAIN:     gain_r    <= cfg_wdata[3:0];
        sbq_pkg::REG_MODE:     mode_r    <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cur_slot  = hist_idx_r;
  assign old_slot  = (hist_idx_r == 2'd2) ? 2'd0 : hist_idx_r + 2'd1;
  assign mid_slot  = (hist_idx_r == 2'd0) ? 2'd2 : hist_idx_r - 2'd1;
  assign next_slot = (hist_idx_r == 2'd2) ? 2'd0 : hist_idx_r + 2'd1;

  // tap decode: per channel b_old, a_old, b_mid, a_mid, b_new, a_stale
  assign tap_ch  = (cmd.tap >= sbq_pkg::TAPS_PER_CH);
  assign tap_loc = tap_ch ? 3'(cmd.tap - sbq_pkg::TAPS_PER_CH) : cmd.tap[2:0];
  assign coef_sel = tap_loc[0] ? 3'(3'd3 + {1'b0, tap_loc[2:1]}) : {1'b0, tap_loc[2:1]};

  always_comb begin
    case (tap_loc[2:1])
      sbq_pkg::SLOT_OLD: sel_slot = old_slot;
      sbq_pkg::SLOT_MID: sel_slot = mid_slot;
      default:           sel_slot = cur_slot;
    endcase
    operand = tap_loc[0] ? out_hist_r[{sel_slot, tap_ch}] : in_hist_r[{sel_slot, tap_ch}];
  end

  assign gain_eff = (gain_r > sbq_pkg::BASE_SHIFT) ? sbq_pkg::BASE_SHIFT : gain_r;
  assign shamt    = sbq_pkg::BASE_SHIFT - gain_eff;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (acc_r[c] > sbq_pkg::SAT_HIGH)     sat_v[c] = sbq_pkg::SAT_HIGH[sbq_pkg::SAT_W-1:0];
      else if (acc_r[c] < sbq_pkg::SAT_LOW) sat_v[c] = sbq_pkg::SAT_LOW[sbq_pkg::SAT_W-1:0];
      else                                  sat_v[c] = acc_r[c][sbq_pkg::SAT_W-1:0];
      shift_v[c] = sat_v[c] >>> shamt;
    end
  end

  // histories and index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_idx_r <= sbq_pkg::HIST_IDX_RESET;
      for (int i = 0; i < 6; i++) begin
        in_hist_r[i]  <= '0;
        out_hist_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        hist_idx_r                    <= next_slot;
        in_hist_r[{next_slot, 1'b0}]  <= left_in;
        in_hist_r[{next_slot, 1'b1}]  <= right_in;
      end
      if (cmd.sat) begin
        out_hist_r[{cur_slot, 1'b0}] <= shift_v[0][sbq_pkg::SAMPLE_W-1:0];
        out_hist_r[{cur_slot, 1'b1}] <= shift_v[1][sbq_pkg::SAMPLE_W-1:0];
      end
    end
  end

  // shared multiplier, registered ahead of the accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r     <= 32'(coef_r[coef_sel]) * 32'(operand);
      prod_sub_r <= tap_loc[0];
      prod_ch_r  <= tap_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
    end else if (prod_vld_r) begin
      if (prod_sub_r) acc_r[prod_ch_r] <= acc_r[prod_ch_r] - (prod_r >>> 2);
      else            acc_r[prod_ch_r] <= acc_r[prod_ch_r] + (prod_r >>> 2);
    end
  end

  // mode select on the stored filter output
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      logic signed [sbq_pkg::SAMPLE_W:0] x_ext;
      logic signed [sbq_pkg::SAMPLE_W:0] y_ext;
      logic signed [sbq_pkg::SAMPLE_W:0] mix;
      x_ext = {in_hist_r[{cur_slot, c[0]}][sbq_pkg::SAMPLE_W-1], in_hist_r[{cur_slot, c[0]}]};
      y_ext = {out_hist_r[{cur_slot, c[0]}][sbq_pkg::SAMPLE_W-1], out_hist_r[{cur_slot, c[0]}]};
      case (mode_r)
        sbq_pkg::MODE_BANDPASS: begin
          mix      = x_ext - y_ext;
          res_v[c] = mix[sbq_pkg::SAMPLE_W:1];
        end
        sbq_pkg::MODE_BANDREJECT: begin
          mix      = x_ext + y_ext;
          res_v[c] = mix[sbq_pkg::SAMPLE_W:1];
        end
        default: begin
          mix      = y_ext;
          res_v[c] = mix[sbq_pkg::SAMPLE_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_left_r  <= res_v[0];
      out_right_r <= res_v[1];
    end
  end

  assign left_out  = out_left_r;
  assign right_out = out_right_r;

endmodule

// File: rtl/stereo_biquad_filter.sv
// ----------------------------------------------------------------------------
// Stereo biquad filter
// Direct form 1 biquad on a stereo pair with plain, band-pass and band-reject.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one stereo word (left_in, right_in); out_ch returns one
//   filtered word (left_out, right_out) for every word taken in.
//   cfg_wr_en/cfg_index/cfg_wdata write the coefficient, gain and mode
//   registers; write them only while no word is in flight.
// Sequence:
//   The accepting edge loads the histories; then come twelve multiply issues
//   on the single shared 16x16 multiplier (six taps per channel), a drain of
//   the product register, a step to saturate and store the new outputs and a
//   step that loads the mode result, after which out_ch.valid rises. A new
//   word is accepted only after the previous one has left this sequence, so
//   words do not overlap.
// Reset:
//   rst_n (synchronous) clears the sample histories, returns the registers
//   to their default coefficients and empties the output register.
// Stall:
//   The output register holds its word while out_ch.ready is low; the next
//   word may still be accepted and run up to the final step, where it waits.
module stereo_biquad_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  sbq_in_if.sink                              in_ch,
  sbq_out_if.source                           out_ch,
  input  logic                                cfg_wr_en,
  input  logic [sbq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  sbq_pkg::cmd_t cmd;

  sbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sbq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .left_in   (in_ch.left_in),
    .right_in  (in_ch.right_in),
    .left_out  (out_ch.left_out),
    .right_out (out_ch.right_out)
  );

endmodule
